@@ rtl/quaternion_vector_rotate_assert.svh @@
// Assertion macros for the quaternion vector rotator.
// Expects clk and rst_n in the scope of use; no other dependencies.
`ifndef QUATERNION_VECTOR_ROTATE_ASSERT_SVH
`define QUATERNION_VECTOR_ROTATE_ASSERT_SVH

// Same-cycle implication, checked out of reset only.
`define QVR_ASSERT_IMPLY(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("qvr assertion failed");

// Next-cycle implication, checked out of reset only.
`define QVR_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("qvr assertion failed");

`endif

@@ rtl/qvr_pkg.sv @@
// Shared types and constants for the quaternion vector rotator.
// No dependencies; imported by qvr_coef, quaternion_vector_rotate and the testbench.
`timescale 1ns / 1ps

package qvr_pkg;

    localparam int QUAT_W     = 16;  // quaternion register width, Q1.F
    localparam int QPROD_W    = 32;  // one pairwise quaternion product
    localparam int COEF_W     = 34;  // rotation matrix weight, e.g. 2*(xy - wz)
    localparam int NUM_AXES   = 3;
    localparam int CFG_ADDR_W = 2;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_QUAT_W = 2'd0,
        REG_QUAT_X = 2'd1,
        REG_QUAT_Y = 2'd2,
        REG_QUAT_Z = 2'd3
    } cfg_reg_t;

    typedef logic signed [QUAT_W-1:0] quat_part_t;

    typedef struct packed {
        quat_part_t w;
        quat_part_t x;
        quat_part_t y;
        quat_part_t z;
    } quat_t;

    typedef logic signed [COEF_W-1:0] coef_t;

    // [row][column] of the rotation matrix, scaled by 2^(2F)
    typedef coef_t [NUM_AXES-1:0][NUM_AXES-1:0] coef_matrix_t;

endpackage

@@ rtl/qvr_coef.sv @@
// Rotation matrix weights from the quaternion registers, two register stages.
// Depends on qvr_pkg.
`timescale 1ns / 1ps

module qvr_coef
    import qvr_pkg::*;
(
    input  logic         clk,
    input  quat_t        quat,
    output coef_matrix_t coef
);

    logic signed [QPROD_W-1:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [QPROD_W-1:0] wx_reg, wy_reg, wz_reg;
    logic signed [QPROD_W-1:0] xy_reg, xz_reg, yz_reg;
    coef_matrix_t              coef_reg;
    coef_matrix_t              coef_next;

    // Ten pairwise products, exact
    always_ff @(posedge clk)
    begin
        ww_reg <= quat.w * quat.w;
        xx_reg <= quat.x * quat.x;
        yy_reg <= quat.y * quat.y;
        zz_reg <= quat.z * quat.z;
        wx_reg <= quat.w * quat.x;
        wy_reg <= quat.w * quat.y;
        wz_reg <= quat.w * quat.z;
        xy_reg <= quat.x * quat.y;
        xz_reg <= quat.x * quat.z;
        yz_reg <= quat.y * quat.z;
    end

    always_comb
    begin
        coef_next[0][0] = COEF_W'(ww_reg) + COEF_W'(xx_reg) - COEF_W'(yy_reg) - COEF_W'(zz_reg);
        coef_next[0][1] = (COEF_W'(xy_reg) - COEF_W'(wz_reg)) <<< 1;
        coef_next[0][2] = (COEF_W'(xz_reg) + COEF_W'(wy_reg)) <<< 1;
        coef_next[1][0] = (COEF_W'(xy_reg) + COEF_W'(wz_reg)) <<< 1;
        coef_next[1][1] = COEF_W'(ww_reg) - COEF_W'(xx_reg) + COEF_W'(yy_reg) - COEF_W'(zz_reg);
        coef_next[1][2] = (COEF_W'(yz_reg) - COEF_W'(wx_reg)) <<< 1;
        coef_next[2][0] = (COEF_W'(xz_reg) - COEF_W'(wy_reg)) <<< 1;
        coef_next[2][1] = (COEF_W'(yz_reg) + COEF_W'(wx_reg)) <<< 1;
        coef_next[2][2] = COEF_W'(ww_reg) - COEF_W'(xx_reg) - COEF_W'(yy_reg) + COEF_W'(zz_reg);
    end

    always_ff @(posedge clk)
    begin
        coef_reg <= coef_next;
    end

    assign coef = coef_reg;

endmodule

@@ rtl/quaternion_vector_rotate.sv @@
// Channel   Dir  Beat contents (low bits first)
// s_axis    in   tdata: vec_x, vec_y, vec_z
// m_axis    out  tdata: rot_x, rot_y, rot_z; tuser: clipped
// cfg       in   cfg_wen/cfg_addr/cfg_wdata: quat_w, quat_x, quat_y, quat_z
//
// One beat per cycle unless m_axis stalls; stages: input register,
// delay stage, nine multipliers, three-way sum, round and saturate.
// Weights follow a quaternion write through the product and weight registers of qvr_coef.
// A stall on m_axis holds every vector stage, not the qvr_coef registers; s_axis_tready drops with it.
// Reset clears the valid bits and loads the identity quaternion.
// Depends on qvr_pkg, qvr_coef and quaternion_vector_rotate_assert.svh.
`timescale 1ns / 1ps
`include "quaternion_vector_rotate_assert.svh"

module quaternion_vector_rotate
    import qvr_pkg::*;
#(
    parameter int VECTOR_WIDTH       = 16,
    parameter int QUAT_FRACTION_BITS = 14
)
(
    input  logic                                       clk,
    input  logic                                       rst_n,
    // vec_x, vec_y, vec_z
    input  logic [((NUM_AXES*VECTOR_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    input  logic                                       s_axis_tvalid,
    output logic                                       s_axis_tready,
    // rot_x, rot_y, rot_z
    output logic [((NUM_AXES*VECTOR_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // clipped
    output logic                                       m_axis_tuser,
    output logic                                       m_axis_tvalid,
    input  logic                                       m_axis_tready,
    input  logic                                       cfg_wen,
    input  logic [CFG_ADDR_W-1:0]                      cfg_addr,
    input  logic [QUAT_W-1:0]                          cfg_wdata
);

    localparam int VW      = VECTOR_WIDTH;
    localparam int SHIFT   = 2 * QUAT_FRACTION_BITS;
    localparam int DATA_W  = ((NUM_AXES*VW+7)/8)*8;
    localparam int MUL_W   = COEF_W + VW;
    localparam int ACC_W   = (COEF_W + VW + 2 > SHIFT + VW + 1) ? COEF_W + VW + 2
                                                                : SHIFT + VW + 1;
    localparam int RS_W    = ACC_W - SHIFT;
    localparam logic signed [ACC_W-1:0] HALF =
        {{(ACC_W-1){1'b0}}, 1'b1} << (SHIFT - 1);
    localparam logic signed [VW-1:0] SAT_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] SAT_MIN = {1'b1, {(VW-1){1'b0}}};
    localparam logic signed [QUAT_W-1:0] QUAT_W_RESET =
        QUAT_W'((QUAT_FRACTION_BITS >= QUAT_W - 1) ? (2**(QUAT_W-1) - 1)
                                                    : (2**QUAT_FRACTION_BITS));

    quat_t                      quat_reg;
    coef_matrix_t               coef;
    logic                       ce;

    logic                       v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic signed [VW-1:0]       vec1_reg [NUM_AXES];
    logic signed [VW-1:0]       vec2_reg [NUM_AXES];
    logic signed [MUL_W-1:0]    mul_reg  [NUM_AXES][NUM_AXES];
    logic signed [ACC_W-1:0]    acc_reg  [NUM_AXES];
    logic signed [VW-1:0]       rot_reg  [NUM_AXES];
    logic signed [VW-1:0]       rot_next [NUM_AXES];
    logic                       clip_reg;
    logic                       clip_next;

    // Quaternion registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quat_reg.w <= QUAT_W_RESET;
            quat_reg.x <= '0;
            quat_reg.y <= '0;
            quat_reg.z <= '0;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_QUAT_W: quat_reg.w <= cfg_wdata;
                REG_QUAT_X: quat_reg.x <= cfg_wdata;
                REG_QUAT_Y: quat_reg.y <= cfg_wdata;
                REG_QUAT_Z: quat_reg.z <= cfg_wdata;
                default:    quat_reg   <= quat_reg;
            endcase
        end
    end

    qvr_coef u_coef
    (
        .clk  (clk),
        .quat (quat_reg),
        .coef (coef)
    );

    // Advance every vector stage unless a finished beat is waiting
    assign ce            = !v5_reg || m_axis_tready;
    assign s_axis_tready = ce;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (ce)
        begin
            v1_reg <= s_axis_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // Round-half-up of the sum by 2^(2F), then clamp to the vector range
    always_comb
    begin
        logic signed [RS_W-1:0] rs;
        logic                   ovf;
        clip_next = 1'b0;
        for (int r = 0; r < NUM_AXES; r++)
        begin
            rs  = acc_reg[r][ACC_W-1:SHIFT];
            ovf = !((&rs[RS_W-1:VW-1]) || !(|rs[RS_W-1:VW-1]));
            if (ovf)
                rot_next[r] = rs[RS_W-1] ? SAT_MIN : SAT_MAX;
            else
                rot_next[r] = rs[VW-1:0];
            clip_next = clip_next | ovf;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                vec1_reg[a] <= s_axis_tdata[a*VW +: VW];
                vec2_reg[a] <= vec1_reg[a];
            end
            for (int r = 0; r < NUM_AXES; r++)
            begin
                for (int c = 0; c < NUM_AXES; c++)
                begin
                    mul_reg[r][c] <= $signed(coef[r][c]) * vec2_reg[c];
                end
                acc_reg[r] <= ACC_W'(mul_reg[r][0]) + ACC_W'(mul_reg[r][1])
                            + ACC_W'(mul_reg[r][2]) + HALF;
                rot_reg[r] <= rot_next[r];
            end
            clip_reg <= clip_next;
        end
    end

    assign m_axis_tdata  = DATA_W'({rot_reg[2], rot_reg[1], rot_reg[0]});
    assign m_axis_tuser  = clip_reg;
    assign m_axis_tvalid = v5_reg;

    `QVR_ASSERT_IMPLY(a_stall_only_on_held_beat, !s_axis_tready,
        m_axis_tvalid && !m_axis_tready)
    `QVR_ASSERT_NEXT(a_sum_stage_advances, ce && v3_reg, v4_reg)
    `QVR_ASSERT_IMPLY(a_clip_at_bound, m_axis_tvalid && m_axis_tuser,
        rot_reg[0] == SAT_MAX || rot_reg[0] == SAT_MIN ||
        rot_reg[1] == SAT_MAX || rot_reg[1] == SAT_MIN ||
        rot_reg[2] == SAT_MAX || rot_reg[2] == SAT_MIN)

endmodule

@@ test/tb_quaternion_vector_rotate.sv @@
// Self-checking testbench for quaternion_vector_rotate: random stream beats on both sides,
// quaternion changes between phases, every output beat compared with an in-bench rotation.
// Depends on qvr_pkg and the quaternion_vector_rotate RTL.
`timescale 1ns / 1ps

module tb_quaternion_vector_rotate;

    import qvr_pkg::*;

    localparam int VEC_W     = 16;
    localparam int FRAC      = 14;
    localparam int TDATA_W   = ((NUM_AXES * VEC_W + 7) / 8) * 8;
    localparam int CYCLE_CAP = 200000;
    localparam int VEC_MAX   = 32767;
    localparam int VEC_MIN   = -32768;

    // x in the low bits, z on top
    typedef struct packed {
        logic signed [VEC_W-1:0] z;
        logic signed [VEC_W-1:0] y;
        logic signed [VEC_W-1:0] x;
    } vec3_t;

    typedef struct {
        vec3_t rot;
        logic  clipped;
    } rotation_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic [TDATA_W-1:0] s_axis_tdata = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] m_axis_tdata;
    logic               m_axis_tuser;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic               cfg_wen = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = REG_QUAT_W;
    logic [QUAT_W-1:0]  cfg_wdata = '0;

    vec3_t     vec_backlog[$];
    rotation_t rot_expected[$];
    quat_t     quat_now;
    logic      in_taken = 1'b0;
    logic      steady = 1'b0;
    int        mismatches = 0;
    int        cycle_count = 0;

    quaternion_vector_rotate #(
        .VECTOR_WIDTH      (VEC_W),
        .QUAT_FRACTION_BITS(FRAC)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .cfg_wen      (cfg_wen),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // q v q* through the expanded rotation matrix, round half up, saturate
    function automatic rotation_t rotate_vector(quat_t q, vec3_t v);
        longint    qw, qx, qy, qz;
        longint    ww, xx, yy, zz, wx, wy, wz, xy, xz, yz;
        longint    wt[3][3];
        longint    lane[3];
        longint    acc;
        rotation_t res;
        qw = $signed(q.w);
        qx = $signed(q.x);
        qy = $signed(q.y);
        qz = $signed(q.z);
        ww = qw * qw;  xx = qx * qx;  yy = qy * qy;  zz = qz * qz;
        wx = qw * qx;  wy = qw * qy;  wz = qw * qz;
        xy = qx * qy;  xz = qx * qz;  yz = qy * qz;
        wt[0][0] = ww + xx - yy - zz;  wt[0][1] = 2 * (xy - wz);  wt[0][2] = 2 * (xz + wy);
        wt[1][0] = 2 * (xy + wz);  wt[1][1] = ww - xx + yy - zz;  wt[1][2] = 2 * (yz - wx);
        wt[2][0] = 2 * (xz - wy);  wt[2][1] = 2 * (yz + wx);  wt[2][2] = ww - xx - yy + zz;
        res.clipped = 1'b0;
        for (int row = 0; row < 3; row++)
        begin
            acc = wt[row][0] * longint'($signed(v.x)) + wt[row][1] * longint'($signed(v.y))
                + wt[row][2] * longint'($signed(v.z)) + (longint'(1) << (2 * FRAC - 1));
            lane[row] = acc >>> (2 * FRAC);
            if (lane[row] > VEC_MAX)
            begin
                lane[row] = VEC_MAX;
                res.clipped = 1'b1;
            end
            if (lane[row] < VEC_MIN)
            begin
                lane[row] = VEC_MIN;
                res.clipped = 1'b1;
            end
        end
        res.rot.x = lane[0][VEC_W-1:0];
        res.rot.y = lane[1][VEC_W-1:0];
        res.rot.z = lane[2][VEC_W-1:0];
        return res;
    endfunction

    // source side: hold a beat until taken, then advance or idle
    always @(negedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || in_taken)
        begin
            if (vec_backlog.size() != 0 && (steady || $urandom_range(0, 99) >= 28))
            begin
                s_axis_tdata  <= vec_backlog.pop_front();
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= steady || ($urandom_range(0, 99) >= 28);
    end

    always @(posedge clk)
    begin : monitor
        rotation_t exp_rot;
        vec3_t     got;
        in_taken <= s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
            rot_expected.push_back(rotate_vector(quat_now, vec3_t'(s_axis_tdata)));
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = vec3_t'(m_axis_tdata);
            if (rot_expected.size() == 0)
            begin
                $display("%0t unexpected beat: expected none, got x=%0d y=%0d z=%0d clipped=%0b",
                         $time, got.x, got.y, got.z, m_axis_tuser);
                mismatches++;
            end
            else
            begin
                exp_rot = rot_expected.pop_front();
                if (got.x !== exp_rot.rot.x || got.y !== exp_rot.rot.y
                    || got.z !== exp_rot.rot.z || m_axis_tuser !== exp_rot.clipped)
                begin
                    $display("%0t mismatch: expected %0d %0d %0d/%0b, got %0d %0d %0d/%0b",
                             $time, exp_rot.rot.x, exp_rot.rot.y, exp_rot.rot.z,
                             exp_rot.clipped, got.x, got.y, got.z, m_axis_tuser);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic push_vec(input int x, input int y, input int z);
        vec3_t v;
        v.x = x[VEC_W-1:0];
        v.y = y[VEC_W-1:0];
        v.z = z[VEC_W-1:0];
        vec_backlog.push_back(v);
    endtask

    // wait until the pipeline is empty, then let it settle
    task automatic drain();
        while (vec_backlog.size() != 0 || s_axis_tvalid || rot_expected.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input quat_part_t value);
        @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_wen <= 1'b0;
        case (idx)
            REG_QUAT_W: quat_now.w = value;
            REG_QUAT_X: quat_now.x = value;
            REG_QUAT_Y: quat_now.y = value;
            REG_QUAT_Z: quat_now.z = value;
        endcase
    endtask

    // keep the low register bits of each part
    task automatic load_quat(input int w, input int x, input int y, input int z);
        drain();
        write_reg(REG_QUAT_W, quat_part_t'(w));
        write_reg(REG_QUAT_X, quat_part_t'(x));
        write_reg(REG_QUAT_Y, quat_part_t'(y));
        write_reg(REG_QUAT_Z, quat_part_t'(z));
    endtask

    // random direction, scaled to unit length in Q1.14
    task automatic load_unit_quat();
        int  raw[4];
        real norm;
        norm = 0.0;
        for (int i = 0; i < 4; i++)
        begin
            raw[i] = $urandom_range(0, 32768) - 16384;
            norm   = norm + real'(raw[i]) * real'(raw[i]);
        end
        if (norm < 1.0)
            load_quat(16384, 0, 0, 0);
        else
        begin
            norm = $sqrt(norm);
            load_quat($rtoi(raw[0] * 16384.0 / norm), $rtoi(raw[1] * 16384.0 / norm),
                      $rtoi(raw[2] * 16384.0 / norm), $rtoi(raw[3] * 16384.0 / norm));
        end
    endtask

    function automatic int random_lane();
        int pick;
        pick = $urandom_range(0, 7);
        case (pick)
            0: return VEC_MAX;
            1: return VEC_MIN;
            2, 3: return $urandom_range(0, 64) - 32;
            default: return int'($signed(16'($urandom())));
        endcase
    endfunction

    task automatic push_random(input int count);
        for (int i = 0; i < count; i++)
            push_vec(random_lane(), random_lane(), random_lane());
    endtask

    initial
    begin
        quat_now.w = 16384;
        quat_now.x = 0;
        quat_now.y = 0;
        quat_now.z = 0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // identity after reset
        push_vec(0, 0, 0);
        push_vec(VEC_MAX, VEC_MAX, VEC_MAX);
        push_vec(VEC_MIN, VEC_MIN, VEC_MIN);
        push_vec(VEC_MAX, VEC_MIN, 1);
        push_vec(-1, -1, -1);
        push_vec(21845, -21846, 0);
        push_vec(-21846, 21845, 1);

        // half turn about x: negating the minimum saturates
        load_quat(0, 16384, 0, 0);
        push_vec(VEC_MIN, VEC_MIN, VEC_MIN);
        push_vec(VEC_MAX, 0, -1);

        // largest non-unit quaternion, heavy clipping both ways
        load_quat(-32768, -32768, -32768, -32768);
        push_vec(VEC_MAX, VEC_MAX, VEC_MAX);
        push_vec(VEC_MIN, VEC_MAX, VEC_MIN);
        push_vec(1, 0, -1);

        // half-length quaternion scales by a quarter: exercises round half up
        load_quat(8192, 0, 0, 0);
        push_vec(2, -2, 6);
        push_vec(-6, 1, -1);
        push_vec(VEC_MAX, VEC_MIN, 3);

        load_quat(32767, 32767, 32767, 32767);
        push_vec(1, -1, 1);
        push_vec(VEC_MIN, VEC_MAX, 0);

        // quarter turn about z
        load_quat(11585, 0, 0, 11585);
        push_vec(VEC_MAX, 0, 0);
        push_vec(100, -100, VEC_MIN);

        for (int phase = 0; phase < 8; phase++)
        begin
            if (phase == 2 || phase == 6)
                load_quat($urandom(), $urandom(), $urandom(), $urandom());
            else
                load_unit_quat();
            steady = (phase == 3);
            push_random(phase == 3 ? 70 : 48);
        end

        load_quat(16384, 0, 0, 0);
        steady = 1'b0;
        push_random(20);

        drain();
        repeat (12) @(negedge clk);
        if (mismatches == 0 && rot_expected.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/qvr_pkg.sv
rtl/qvr_coef.sv
rtl/quaternion_vector_rotate.sv
test/tb_quaternion_vector_rotate.sv
